/* rtl/core/smp_pkg.sv */
// ----------------------------------------------------------------------------
// smp_pkg
// Shared constants and types for the SHA-256 message padder.
// ----------------------------------------------------------------------------
`default_nettype none

package smp_pkg;

	// Depth of the command queue between front and back
	localparam int unsigned QueueDepth = 2;

	// Marker byte that follows the message
	localparam logic [7:0] PadMark = 8'h80;

	// Word index of the high length word within a 512-bit block
	localparam logic [3:0] LenWordPos = 4'd14;

	// Length increment per message byte, in bits
	localparam logic [63:0] BitsPerByte = 64'd8;

	// One command from the front: an optional completed data word and,
	// at message end, everything the back needs to emit the padding.
	typedef struct packed {
		logic        has_word;
		logic [31:0] data_word;
		logic        is_end;
		logic [31:0] pad_word;
		logic [3:0]  zero_words;
		logic [63:0] bit_count;
	} smp_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/smp_if.sv */
// ----------------------------------------------------------------------------
// smp_if
// Valid/ready channels for message bytes in and padded words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output has_byte,
		output end_of_message, input ready);
	modport sink (input valid, input data_byte, input has_byte,
		input end_of_message, output ready);
endinterface

interface smp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] word;
	logic        last_word;

	modport source (output valid, output word, output last_word, input ready);
	modport sink (input valid, input word, input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/core/smp_front.sv */
// ----------------------------------------------------------------------------
// smp_front
// Packs message bytes into words, tracks length and block position, and
// turns each request into at most one command for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	smp_in_if.sink            msg,
	output smp_pkg::smp_cmd_t cmd,
	output logic              cmd_valid,
	input  wire logic         cmd_ready
);

	logic [5:0]  pos_q;
	logic [23:0] part_q;
	logic [63:0] bits_q;

	logic        take;
	logic        word_done;
	logic [5:0]  pos_nxt;
	logic [23:0] part_nxt;
	logic [63:0] bits_nxt;
	logic [31:0] pad_word;
	logic [3:0]  next_widx;

	assign msg.ready = cmd_ready;
	assign take      = msg.valid && msg.ready;

	// Byte packing: the fourth byte of a word completes it
	always_comb begin
		word_done = msg.has_byte && (pos_q[1:0] == 2'd3);
		pos_nxt   = pos_q + {5'd0, msg.has_byte};
		bits_nxt  = msg.has_byte ? (bits_q + smp_pkg::BitsPerByte) : bits_q;
		if (!msg.has_byte) begin
			part_nxt = part_q;
		end else if (word_done) begin
			part_nxt = 24'd0;
		end else begin
			part_nxt = {part_q[15:0], msg.data_byte};
		end
	end

	// Word holding the marker byte, zero filled to the word boundary
	always_comb begin
		case (pos_nxt[1:0])
			2'd0:    pad_word = {smp_pkg::PadMark, 24'd0};
			2'd1:    pad_word = {part_nxt[7:0], smp_pkg::PadMark, 16'd0};
			2'd2:    pad_word = {part_nxt[15:0], smp_pkg::PadMark, 8'd0};
			default: pad_word = {part_nxt[23:0], smp_pkg::PadMark};
		endcase
		// zero words run from the word after the marker up to the length slot
		next_widx = pos_nxt[5:2] + 4'd1;
	end

	// Command towards the back
	always_comb begin
		cmd.has_word   = word_done;
		cmd.data_word  = {part_q, msg.data_byte};
		cmd.is_end     = msg.end_of_message;
		cmd.pad_word   = pad_word;
		cmd.zero_words = smp_pkg::LenWordPos - next_widx;
		cmd.bit_count  = bits_nxt;
		cmd_valid      = msg.valid && (word_done || msg.end_of_message);
	end

	// Message state, cleared at message end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 6'd0;
			part_q <= 24'd0;
			bits_q <= 64'd0;
		end else if (take) begin
			if (msg.end_of_message) begin
				pos_q  <= 6'd0;
				part_q <= 24'd0;
				bits_q <= 64'd0;
			end else begin
				pos_q  <= pos_nxt;
				part_q <= part_nxt;
				bits_q <= bits_nxt;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/smp_queue.sv */
// ----------------------------------------------------------------------------
// smp_queue
// Small command FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_queue #(
	parameter int unsigned DEPTH = smp_pkg::QueueDepth
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smp_pkg::smp_cmd_t push_cmd,
	input  wire logic              push_valid,
	output logic                   push_ready,
	output smp_pkg::smp_cmd_t      head_cmd,
	output logic                   head_valid,
	input  wire logic              pop
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	smp_pkg::smp_cmd_t mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/smp_back.sv */
// ----------------------------------------------------------------------------
// smp_back
// Expands queued commands into padded-message words, one per cycle while
// the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module smp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smp_pkg::smp_cmd_t head_cmd,
	input  wire logic              head_valid,
	output logic                   pop,
	smp_out_if.source              padded
);

	localparam logic [2:0] PH_DATA = 3'd0;
	localparam logic [2:0] PH_PAD  = 3'd1;
	localparam logic [2:0] PH_ZERO = 3'd2;
	localparam logic [2:0] PH_HI   = 3'd3;
	localparam logic [2:0] PH_LO   = 3'd4;

	logic [2:0]  ph_q;
	logic [3:0]  zcnt_q;
	logic        valid_q;
	logic [31:0] word_q;
	logic        last_q;

	logic        advance;
	logic [2:0]  ph_eff;
	logic [2:0]  ph_nxt;
	logic [3:0]  zcnt_nxt;
	logic [31:0] word_nxt;
	logic        last_nxt;

	assign padded.valid     = valid_q;
	assign padded.word      = word_q;
	assign padded.last_word = last_q;

	assign advance = head_valid && (!valid_q || padded.ready);

	// Sequencer: data word, marker word, zero words, length high, length low
	always_comb begin
		ph_eff   = (ph_q == PH_DATA && !head_cmd.has_word) ? PH_PAD : ph_q;
		ph_nxt   = ph_q;
		zcnt_nxt = zcnt_q;
		word_nxt = 32'd0;
		last_nxt = 1'b0;
		pop      = 1'b0;
		case (ph_eff)
			PH_DATA: begin
				word_nxt = head_cmd.data_word;
				if (head_cmd.is_end) begin
					ph_nxt = PH_PAD;
				end else begin
					pop = advance;
				end
			end
			PH_PAD: begin
				word_nxt = head_cmd.pad_word;
				zcnt_nxt = head_cmd.zero_words;
				ph_nxt   = (head_cmd.zero_words != 4'd0) ? PH_ZERO : PH_HI;
			end
			PH_ZERO: begin
				zcnt_nxt = zcnt_q - 4'd1;
				ph_nxt   = (zcnt_q == 4'd1) ? PH_HI : PH_ZERO;
			end
			PH_HI: begin
				word_nxt = head_cmd.bit_count[63:32];
				ph_nxt   = PH_LO;
			end
			PH_LO: begin
				word_nxt = head_cmd.bit_count[31:0];
				last_nxt = 1'b1;
				ph_nxt   = PH_DATA;
				pop      = advance;
			end
			default: begin
				ph_nxt = PH_DATA;
			end
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_DATA;
			zcnt_q <= 4'd0;
		end else if (advance) begin
			ph_q   <= ph_nxt;
			zcnt_q <= zcnt_nxt;
		end
	end

	// Output stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (padded.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			word_q <= word_nxt;
			last_q <= last_nxt;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sha256_message_padder.sv */
// ----------------------------------------------------------------------------
// sha256_message_padder
// Streams message bytes in and SHA-256 padded big-endian 32-bit words out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  msg      in   valid / ready    data_byte[7:0], has_byte, end_of_message
//  padded   out  valid / ready    word[31:0], last_word
//
//  One byte request is taken per cycle while the command queue has room.
//  Words leave at one per cycle from the output register while the sink is
//  ready; a message end adds marker, zero fill and two length words, set by
//  the back-end sequencer. The front keeps taking bytes meanwhile until the
//  queue fills. Reset clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_padder #(
	parameter int unsigned QUEUE_DEPTH = smp_pkg::QueueDepth
) (
	input  wire logic clk,
	input  wire logic arst_n,
	smp_in_if.sink    msg,
	smp_out_if.source padded
);

	smp_pkg::smp_cmd_t front_cmd;
	logic              front_valid;
	logic              front_ready;
	smp_pkg::smp_cmd_t head_cmd;
	logic              head_valid;
	logic              head_pop;

	smp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	smp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.pop        (head_pop)
	);

	smp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.pop        (head_pop),
		.padded     (padded)
	);

endmodule

`default_nettype wire

/* rtl/core/smp_checker.sv */
// ----------------------------------------------------------------------------
// smp_checker
// Port-level checks on the padder: output hold, empty output after reset,
// block alignment of each padded message, and no message end without a
// preceding end request.
`default_nettype none

module smp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        msg_valid,
	input wire logic        msg_ready,
	input wire logic        msg_end,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_word,
	input wire logic        out_last
);

	logic       msg_take;
	logic       out_take;
	logic [3:0] words_q;
	logic [3:0] pending_q;

	assign msg_take = msg_valid && msg_ready;
	assign out_take = out_valid && out_ready;

	// Words since the last message end, modulo one block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= 4'd0;
		end else if (out_take) begin
			words_q <= out_last ? 4'd0 : words_q + 4'd1;
		end
	end

	// End requests taken but not yet closed by a last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + {3'd0, msg_take && msg_end}
				- {3'd0, out_take && out_last};
		end
	end

	// Stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_last))
		else $error("padded word changed while stalled");

	// Padded message fills whole 512-bit blocks
	a_block_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && out_last |-> words_q == 4'd15)
		else $error("last word not at the end of a block");

	// A last word needs an end request before it
	a_end_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && out_last |-> pending_q != 4'd0)
		else $error("last word without a message end request");

	// Output stage comes out of reset empty
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid straight after reset");

endmodule

bind sha256_message_padder smp_checker u_smp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_valid (msg.valid),
	.msg_ready (msg.ready),
	.msg_end   (msg.end_of_message),
	.out_valid (padded.valid),
	.out_ready (padded.ready),
	.out_word  (padded.word),
	.out_last  (padded.last_word)
);

`default_nettype wire
